/* src/lsfa_pkg.sv */
// ----------------------------------------------------------------------------
// lsfa_pkg - shared types and constants of the label segment feature averager
// Widths, register indexes, controller command/status bundles.
// ----------------------------------------------------------------------------
package lsfa_pkg;

  localparam int MAX_DIM    = 64;
  localparam int IDX_W      = 6;
  localparam int DIM_W      = 7;
  localparam int COUNT_BITS = 16;
  localparam int SUM_W      = 32;
  localparam int TOTAL_W    = 38;
  localparam int NUM_W      = SUM_W + 16;
  localparam int LABEL_W    = 10;
  localparam int VALUE_W    = 16;
  localparam int ADDR_W     = 3;

  // register index, taken from paddr[2]
  localparam logic REG_NORMALIZE   = 1'b0;
  localparam logic REG_FEATURE_DIM = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  typedef struct packed {
    logic latch_in;
    logic clr_all;
    logic emit_init;
    logic rd_emit;
    logic div_start;
    logic out_load;
    logic start_seg;
    logic cont_frame;
    logic rd_acc;
    logic acc_wr;
  } lsfa_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic label_held;
    logic frame_start;
    logic label_match;
    logic div_busy;
    logic out_free;
    logic emit_last;
  } lsfa_status_t;

  // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    return r;
  endfunction

endpackage

/* src/lsfa_ctrl.sv */
// ----------------------------------------------------------------------------
// lsfa_ctrl - sequencing state machine
// Steps each input transaction through emit, segment start, accumulate or clear.
// ----------------------------------------------------------------------------
module lsfa_ctrl import lsfa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  lsfa_status_t status,
  output lsfa_cmd_t    cmd
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_DECIDE = 10'b00_0000_0010,
    ST_EM_RD  = 10'b00_0000_0100,
    ST_EM_DS  = 10'b00_0000_1000,
    ST_EM_DW  = 10'b00_0001_0000,
    ST_EM_OUT = 10'b00_0010_0000,
    ST_NEWSEG = 10'b00_0100_0000,
    ST_CLEAR  = 10'b00_1000_0000,
    ST_ACC_RD = 10'b01_0000_0000,
    ST_ACC_WR = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.is_flush) begin
          if (status.label_held) begin
            cmd.emit_init = 1'b1;
            state_next    = ST_EM_RD;
          end else begin
            state_next = ST_CLEAR;
          end
        end else if (status.frame_start) begin
          if (status.label_held && status.label_match) begin
            cmd.cont_frame = 1'b1;
            state_next     = ST_ACC_RD;
          end else if (status.label_held) begin
            cmd.emit_init = 1'b1;
            state_next    = ST_EM_RD;
          end else begin
            state_next = ST_NEWSEG;
          end
        end else begin
          state_next = ST_ACC_RD;
        end
      end
      ST_EM_RD: begin
        cmd.rd_emit = 1'b1;
        state_next  = ST_EM_DS;
      end
      ST_EM_DS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_EM_DW;
      end
      ST_EM_DW: begin
        if (!status.div_busy) state_next = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (!status.emit_last)    state_next = ST_EM_RD;
          else if (status.is_flush) state_next = ST_CLEAR;
          else                      state_next = ST_NEWSEG;
        end
      end
      ST_NEWSEG: begin
        cmd.start_seg = 1'b1;
        state_next    = ST_ACC_RD;
      end
      ST_CLEAR: begin
        cmd.clr_all = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_ACC_RD: begin
        cmd.rd_acc = 1'b1;
        state_next = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* src/lsfa_dp.sv */
// ----------------------------------------------------------------------------
// lsfa_dp - datapath
// Sum memory, segment registers, bit-serial divider and output register.
// ----------------------------------------------------------------------------
module lsfa_dp import lsfa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  lsfa_cmd_t                 cmd,
  output lsfa_status_t              status,
  input  logic                      normalize_mode,
  input  logic [DIM_W-1:0]          feature_dim,
  input  logic                      func,
  input  logic [LABEL_W-1:0]        frame_label,
  input  logic signed [VALUE_W-1:0] feature_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LABEL_W-1:0]        segment_label,
  output logic [IDX_W-1:0]          element_index,
  output logic signed [SUM_W-1:0]   mean_value,
  output logic [COUNT_BITS-1:0]     segment_frames,
  output logic                      zero_total,
  output logic                      last_element
);

  // latched transaction
  logic                      lat_func;
  logic [LABEL_W-1:0]        lat_label;
  logic signed [VALUE_W-1:0] lat_value;

  // segment state
  logic [SUM_W-1:0]      sums_mem [MAX_DIM];
  logic [MAX_DIM-1:0]    vld;
  logic [TOTAL_W-1:0]    total;
  logic [COUNT_BITS-1:0] count;
  logic [LABEL_W-1:0]    held_label;
  logic                  label_held;
  logic [IDX_W-1:0]      pos;
  logic                  starting;
  logic [IDX_W-1:0]      emit_idx;

  logic [SUM_W-1:0] rd_data;
  logic             rd_vld;
  logic [SUM_W-1:0] sum_rd;

  logic [DIM_W-1:0] dim;
  logic [IDX_W-1:0] pos_eff;
  logic [DIM_W-1:0] pos_inc;
  logic [IDX_W-1:0] rd_addr;

  // divider
  logic [NUM_W-1:0]   dv_quo;
  logic [TOTAL_W-1:0] dv_rem;
  logic [TOTAL_W-1:0] dv_den;
  logic               dv_neg;
  logic               dv_zero;
  logic [5:0]         dv_cnt;
  logic               dv_busy;

  logic [TOTAL_W:0]   rem_sh;
  logic [TOTAL_W+1:0] diff;
  logic               ge;

  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   num_mag;
  logic [TOTAL_W-1:0] den;
  logic [TOTAL_W-1:0] den_mag;

  logic [SUM_W:0]     sum33;
  logic [SUM_W-1:0]   new_sum;
  logic [TOTAL_W:0]   tot39;
  logic [TOTAL_W-1:0] new_total;
  logic [SUM_W-1:0]   q;

  assign dim     = eff_dim(feature_dim);
  assign pos_eff = ({1'b0, pos} >= dim) ? '0 : pos;
  assign pos_inc = {1'b0, pos_eff} + DIM_W'(1);
  assign rd_addr = cmd.rd_emit ? emit_idx : pos_eff;
  assign sum_rd  = rd_vld ? rd_data : '0;

  assign status.is_flush    = lat_func;
  assign status.label_held  = label_held;
  assign status.frame_start = (pos_eff == '0);
  assign status.label_match = (lat_label == held_label);
  assign status.div_busy    = dv_busy;
  assign status.out_free    = !out_valid || !out_stall;
  assign status.emit_last   = (({1'b0, emit_idx} + DIM_W'(1)) == dim);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      lat_func  <= func;
      lat_label <= frame_label;
      lat_value <= feature_value;
    end
  end

  // sum memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd_emit || cmd.rd_acc) begin
      rd_data <= sums_mem[rd_addr];
      rd_vld  <= vld[rd_addr];
    end
    if (cmd.acc_wr) sums_mem[pos_eff] <= new_sum;
  end

  // saturating accumulate
  always_comb begin
    sum33 = {sum_rd[SUM_W-1], sum_rd} + {{(SUM_W-VALUE_W+1){lat_value[VALUE_W-1]}}, lat_value};
    if (starting) new_sum = {{(SUM_W-VALUE_W){lat_value[VALUE_W-1]}}, lat_value};
    else if (sum33[SUM_W] != sum33[SUM_W-1])
      new_sum = sum33[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else new_sum = sum33[SUM_W-1:0];

    tot39 = {total[TOTAL_W-1], total}
          + {{(TOTAL_W-VALUE_W+1){lat_value[VALUE_W-1]}}, lat_value};
    if (tot39[TOTAL_W] != tot39[TOTAL_W-1])
      new_total = tot39[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} : {1'b0, {(TOTAL_W-1){1'b1}}};
    else new_total = tot39[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_all) begin
      vld        <= '0;
      total      <= '0;
      count      <= '0;
      held_label <= '0;
      label_held <= 1'b0;
      pos        <= '0;
      starting   <= 1'b0;
      emit_idx   <= '0;
    end else begin
      if (cmd.emit_init) emit_idx <= '0;
      if (cmd.out_load) begin
        emit_idx      <= emit_idx + IDX_W'(1);
        vld[emit_idx] <= 1'b0;
      end
      if (cmd.cont_frame) begin
        if (count != '1) count <= count + COUNT_BITS'(1);
        starting <= 1'b0;
      end
      if (cmd.start_seg) begin
        held_label <= lat_label;
        label_held <= 1'b1;
        count      <= COUNT_BITS'(1);
        total      <= '0;
        starting   <= 1'b1;
      end
      if (cmd.acc_wr) begin
        vld[pos_eff] <= 1'b1;
        total        <= new_total;
        pos          <= (pos_inc >= dim) ? '0 : pos_inc[IDX_W-1:0];
      end
    end
  end

  // operand magnitudes
  always_comb begin
    num     = {sum_rd, 16'b0};
    num_mag = sum_rd[SUM_W-1] ? (~num + NUM_W'(1)) : num;
    den     = normalize_mode ? total : {{(TOTAL_W-COUNT_BITS){1'b0}}, count};
    den_mag = (normalize_mode && den[TOTAL_W-1]) ? (~den + TOTAL_W'(1)) : den;
  end

  // restoring divider, one quotient bit a cycle
  assign rem_sh = {dv_rem, dv_quo[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, dv_den};
  assign ge     = !diff[TOTAL_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
    end else if (cmd.div_start) begin
      dv_busy <= 1'b1;
    end else if (dv_busy && dv_cnt == 6'(NUM_W-1)) begin
      dv_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_quo  <= num_mag;
      dv_rem  <= '0;
      dv_den  <= den_mag;
      dv_neg  <= sum_rd[SUM_W-1] ^ (normalize_mode & den[TOTAL_W-1]);
      dv_zero <= (den == '0);
      dv_cnt  <= '0;
    end else if (dv_busy) begin
      dv_rem <= ge ? diff[TOTAL_W-1:0] : rem_sh[TOTAL_W-1:0];
      dv_quo <= {dv_quo[NUM_W-2:0], ge};
      dv_cnt <= dv_cnt + 6'd1;
    end
  end

  // sign and saturation of the quotient
  always_comb begin
    if (dv_zero) q = '0;
    else if (!dv_neg)
      q = (|dv_quo[NUM_W-1:SUM_W-1]) ? {1'b0, {(SUM_W-1){1'b1}}} : dv_quo[SUM_W-1:0];
    else if ((|dv_quo[NUM_W-1:SUM_W]) || (dv_quo[SUM_W-1] && |dv_quo[SUM_W-2:0]))
      q = {1'b1, {(SUM_W-1){1'b0}}};
    else q = ~dv_quo[SUM_W-1:0] + SUM_W'(1);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      segment_label  <= held_label;
      element_index  <= emit_idx;
      mean_value     <= q;
      segment_frames <= count;
      zero_total     <= dv_zero & normalize_mode;
      last_element   <= status.emit_last;
    end
  end

endmodule

/* src/label_segment_feature_averager.sv */
// ----------------------------------------------------------------------------
// label_segment_feature_averager - per-segment feature mean / normalisation
// Sums frames sharing a label and emits one result per element on a label
// change or end-of-utterance flush.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  config  | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//  input   | in_valid / in_stall  | func, frame_label, feature_value
//  output  | out_valid / out_stall| segment_label, element_index, mean_value,
//          |                      | segment_frames, zero_total, last_element
//
// An element that opens no emission passes through accept, decide, memory
// read and write back. Each emitted element adds memory read, divider load,
// 48 iterations of the 1-bit restoring divider and a completion step, then
// output load. A new segment adds a segment start step. A flush takes
// accept, decide and a clearing step besides any emission.
// Reset (rst, synchronous) clears all segment state at once via valid bits.
// Output stall holds the sequencer at the output load; in_stall is high
// whenever a transaction is in progress.
module label_segment_feature_averager import lsfa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      func,
  input  logic [LABEL_W-1:0]        frame_label,
  input  logic signed [VALUE_W-1:0] feature_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LABEL_W-1:0]        segment_label,
  output logic [IDX_W-1:0]          element_index,
  output logic signed [SUM_W-1:0]   mean_value,
  output logic [COUNT_BITS-1:0]     segment_frames,
  output logic                      zero_total,
  output logic                      last_element
);

  logic             normalize_mode;
  logic [DIM_W-1:0] feature_dim;
  logic             cfg_wr;

  lsfa_cmd_t    cmd;
  lsfa_status_t status;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      normalize_mode <= 1'b0;
      feature_dim    <= DIM_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_NORMALIZE:   normalize_mode <= pwdata[0];
        REG_FEATURE_DIM: feature_dim    <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NORMALIZE:   prdata = {31'b0, normalize_mode};
      REG_FEATURE_DIM: prdata = {{(32-DIM_W){1'b0}}, feature_dim};
      default:         prdata = '0;
    endcase
  end

  lsfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lsfa_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .normalize_mode (normalize_mode),
    .feature_dim    (feature_dim),
    .func           (func),
    .frame_label    (frame_label),
    .feature_value  (feature_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .segment_label  (segment_label),
    .element_index  (element_index),
    .mean_value     (mean_value),
    .segment_frames (segment_frames),
    .zero_total     (zero_total),
    .last_element   (last_element)
  );

`ifndef SYNTHESIS
  // an accepted transaction keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after a transaction was accepted");

  // a zero divisor always yields a zero value
  a_zero_total_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_total) |-> (mean_value == '0))
    else $error("zero_total set with non-zero mean_value");

  // final element of a segment sits at the last position of the vector
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_element) |->
      ({1'b0, element_index} + DIM_W'(1) == eff_dim(feature_dim)))
    else $error("last_element at wrong element_index");
`endif

endmodule
